[src/assert_macros.svh]
// Assertion helpers used by the checker.
// Both macros expect a signal named clk in the using scope; FCCM_ASSERT also needs rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define FCCM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included
`define FCCM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

[src/fccm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fccm_pkg
// Types, constants and codes of the cluster chain manager.
// ----------------------------------------------------------------------------
package fccm_pkg;

    // Table geometry (entry count must be a power of two)
    localparam int MAP_ENTRIES   = 512;
    localparam int ADDR_W        = $clog2(MAP_ENTRIES);
    localparam int PTR_W         = ADDR_W + 1;
    localparam int CLUSTER_BYTES = 2048;
    localparam int CB_SHIFT      = $clog2(CLUSTER_BYTES);

    // Fixed field widths
    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 24;
    localparam int CL_W     = 9;
    localparam int STATUS_W = 2;
    localparam int LINK_W   = 32;
    localparam int TOTAL_W  = 10;
    localparam int CFG_IDX_W = 2;
    localparam int NEED_W   = BYTE_W - CB_SHIFT + 1;

    // Lowest cluster that can ever be handed out
    localparam logic [ADDR_W-1:0] ALLOC_FLOOR_MIN = ADDR_W'(3);

    // Reset values of the configuration registers
    localparam logic [CL_W-1:0]   FIRST_ALLOC_RST = CL_W'(8);
    localparam logic [LINK_W-1:0] C0_MARK_RST     = 32'h0FFF_FFF0;
    localparam logic [LINK_W-1:0] C1_MARK_RST     = 32'h0FFF_FFFF;
    localparam logic [LINK_W-1:0] EOF_MARK_RST    = 32'h0FFF_FFFF;

    // Fixed entries of the format pattern
    localparam logic [ADDR_W-1:0] ENTRY_C0  = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] ENTRY_C1  = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] ENTRY_EOF = ADDR_W'(2);

    typedef enum logic [CMD_W-1:0] {
        CMD_FORMAT = 2'd0,
        CMD_ALLOC  = 2'd1,
        CMD_FREE   = 2'd2,
        CMD_NEXT   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BAD     = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_ALLOC = 2'd0,
        CFG_C0_MARK     = 2'd1,
        CFG_C1_MARK     = 2'd2,
        CFG_EOF_MARK    = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FORMAT,
        S_CNT_INIT,
        S_CNT,
        S_LINK_INIT,
        S_LINK,
        S_LINK_END,
        S_FREE_HEAD,
        S_FREE_WALK,
        S_CLR_INIT,
        S_CLR,
        S_NEXT_RD,
        S_DONE
    } state_t;

    // Which result the finishing state reports
    typedef enum logic [2:0] {
        RES_FORMAT,
        RES_NOSPACE,
        RES_BAD,
        RES_ALLOC,
        RES_FREE,
        RES_NEXT
    } res_kind_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_SWEEP,
        OP_SCAN_INIT,
        OP_COUNT,
        OP_LINK,
        OP_LINK_END,
        OP_FREE_HEAD,
        OP_FREE_WALK,
        OP_READ_CL,
        OP_FREE_CLR,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t    op;
        logic      reset_marks;
        res_kind_t res;
    } dp_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic scan_done;
        logic short_space;
        logic got_all;
        logic head_bad;
        logic walk_eof;
        logic walk_bad;
        logic rsp_free;
    } dp_sts_t;

endpackage

[src/fccm_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fccm_req_if
// Command channel: one table operation per transaction.
// ----------------------------------------------------------------------------
interface fccm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [23:0] byte_count;
    logic [8:0]  cluster;

    modport source (output valid, cmd, byte_count, cluster, input ready);
    modport sink   (input valid, cmd, byte_count, cluster, output ready);
endinterface

[src/fccm_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fccm_rsp_if
// Result channel: one result per command.
// ----------------------------------------------------------------------------
interface fccm_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] link;
    logic [9:0]  cluster_total;

    modport source (output valid, status, link, cluster_total, input ready);
    modport sink   (input valid, status, link, cluster_total, output ready);
endinterface

[src/fccm_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fccm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface fccm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/fccm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fccm_ctrl
// Sequencer: steps each command through sweeps, scans and chain walks.
// ----------------------------------------------------------------------------
module fccm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [1:0]        req_cmd,
    output logic              req_ready,
    output fccm_pkg::dp_cmd_t dp_cmd,
    input  fccm_pkg::dp_sts_t dp_sts
);
    import fccm_pkg::*;

    state_t    state_reg;
    state_t    state_next;
    res_kind_t res_reg;
    res_kind_t res_next;
    cmd_t      cmd_in;

    assign cmd_in = cmd_t'(req_cmd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            res_reg   <= RES_FORMAT;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (dp_sts.sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (cmd_in)
                        CMD_FORMAT: state_next = S_FORMAT;
                        CMD_ALLOC:  state_next = S_CNT_INIT;
                        CMD_FREE:   state_next = S_FREE_HEAD;
                        CMD_NEXT:   state_next = S_NEXT_RD;
                    endcase
                end
            end
            S_FORMAT:
            begin
                if (dp_sts.sweep_last)
                begin
                    state_next = S_DONE;
                    res_next   = RES_FORMAT;
                end
            end
            S_CNT_INIT:
                state_next = S_CNT;
            S_CNT:
            begin
                if (dp_sts.scan_done)
                begin
                    if (dp_sts.short_space)
                    begin
                        state_next = S_DONE;
                        res_next   = RES_NOSPACE;
                    end
                    else
                        state_next = S_LINK_INIT;
                end
            end
            S_LINK_INIT:
                state_next = S_LINK;
            S_LINK:
            begin
                if (dp_sts.got_all)
                    state_next = S_LINK_END;
            end
            S_LINK_END:
            begin
                state_next = S_DONE;
                res_next   = RES_ALLOC;
            end
            S_FREE_HEAD:
            begin
                if (dp_sts.head_bad)
                begin
                    state_next = S_DONE;
                    res_next   = RES_BAD;
                end
                else
                    state_next = S_FREE_WALK;
            end
            S_FREE_WALK:
            begin
                priority if (dp_sts.walk_bad)
                begin
                    state_next = S_DONE;
                    res_next   = RES_BAD;
                end
                else if (dp_sts.walk_eof)
                    state_next = S_CLR_INIT;
            end
            S_CLR_INIT:
                state_next = S_CLR;
            S_CLR:
            begin
                if (dp_sts.walk_eof)
                begin
                    state_next = S_DONE;
                    res_next   = RES_FREE;
                end
            end
            S_NEXT_RD:
            begin
                state_next = S_DONE;
                res_next   = RES_NEXT;
            end
            S_DONE:
            begin
                if (dp_sts.rsp_free)
                    state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        dp_cmd.op          = OP_NONE;
        dp_cmd.reset_marks = 1'b0;
        dp_cmd.res         = res_reg;
        req_ready          = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                dp_cmd.op          = OP_SWEEP;
                dp_cmd.reset_marks = 1'b1;
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                    dp_cmd.op = OP_LATCH;
            end
            S_FORMAT:    dp_cmd.op = OP_SWEEP;
            S_CNT_INIT:  dp_cmd.op = OP_SCAN_INIT;
            S_CNT:       dp_cmd.op = OP_COUNT;
            S_LINK_INIT: dp_cmd.op = OP_SCAN_INIT;
            S_LINK:      dp_cmd.op = OP_LINK;
            S_LINK_END:  dp_cmd.op = OP_LINK_END;
            S_FREE_HEAD: dp_cmd.op = OP_FREE_HEAD;
            S_FREE_WALK: dp_cmd.op = OP_FREE_WALK;
            S_CLR_INIT:  dp_cmd.op = OP_READ_CL;
            S_CLR:       dp_cmd.op = OP_FREE_CLR;
            S_NEXT_RD:   dp_cmd.op = OP_READ_CL;
            S_DONE:      dp_cmd.op = OP_RESULT;
        endcase
    end

endmodule

[src/fccm_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fccm_dp
// Datapath: link table memory, config registers, scan and walk counters,
// result register.
// ----------------------------------------------------------------------------
module fccm_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fccm_pkg::dp_cmd_t           dp_cmd,
    output fccm_pkg::dp_sts_t           dp_sts,
    input  logic [fccm_pkg::BYTE_W-1:0] req_byte_count,
    input  logic [fccm_pkg::CL_W-1:0]   req_cluster,
    fccm_cfg_if.sink                    cfg,
    fccm_rsp_if.source                  rsp
);
    import fccm_pkg::*;

    // Link table: one write port, one registered read port
    logic [LINK_W-1:0] link_mem [MAP_ENTRIES];

    logic [CL_W-1:0]   first_alloc_reg;
    logic [LINK_W-1:0] c0_mark_reg;
    logic [LINK_W-1:0] c1_mark_reg;
    logic [LINK_W-1:0] eof_mark_reg;

    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  ptr_next;
    logic              dvalid_reg;
    logic              dvalid_next;
    logic [PTR_W-1:0]  cnt_reg;
    logic [PTR_W-1:0]  cnt_next;
    logic [NEED_W-1:0] need_reg;
    logic [NEED_W-1:0] need_next;
    logic [ADDR_W-1:0] cluster_reg;
    logic [ADDR_W-1:0] cluster_next;
    logic [ADDR_W-1:0] head_reg;
    logic [ADDR_W-1:0] head_next;
    logic [ADDR_W-1:0] prev_reg;
    logic [ADDR_W-1:0] prev_next;

    logic [LINK_W-1:0] rdata_reg;
    logic [ADDR_W-1:0] raddr_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [LINK_W-1:0] mem_wdata;

    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic [STATUS_W-1:0] rsp_status_next;
    logic [LINK_W-1:0]   rsp_link_reg;
    logic [LINK_W-1:0]   rsp_link_next;
    logic [TOTAL_W-1:0]  rsp_total_reg;
    logic [TOTAL_W-1:0]  rsp_total_next;

    logic [ADDR_W-1:0] floor_w;
    logic [NEED_W-1:0] need_raw;
    logic              scan_issue;
    logic              free_hit;
    logic              data_eof;
    logic              data_empty;
    logic              data_in_range;
    logic              walk_bad;
    logic [LINK_W-1:0] sweep_data;
    logic              rsp_free;

    assign floor_w = (first_alloc_reg < ALLOC_FLOOR_MIN) ? ALLOC_FLOOR_MIN : first_alloc_reg;

    // ceil(bytes / cluster size); raised to at least one cluster when latched
    assign need_raw = NEED_W'(req_byte_count[BYTE_W-1:CB_SHIFT])
                    + NEED_W'(|req_byte_count[CB_SHIFT-1:0]);

    assign scan_issue = !ptr_reg[PTR_W-1];
    assign free_hit   = dvalid_reg && (rdata_reg == '0);

    // Chain walk checks on the entry value just read
    assign data_eof      = (rdata_reg == eof_mark_reg);
    assign data_empty    = (rdata_reg == '0) && (eof_mark_reg != '0);
    assign data_in_range = (rdata_reg[LINK_W-1:ADDR_W] == '0)
                         && (rdata_reg[ADDR_W-1:0] >= floor_w);
    assign walk_bad      = data_empty
                         || (!data_eof && (!data_in_range || cnt_reg == PTR_W'(MAP_ENTRIES)));

    assign rsp_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        priority if (ptr_reg[ADDR_W-1:0] == ENTRY_C0)
            sweep_data = dp_cmd.reset_marks ? C0_MARK_RST : c0_mark_reg;
        else if (ptr_reg[ADDR_W-1:0] == ENTRY_C1)
            sweep_data = dp_cmd.reset_marks ? C1_MARK_RST : c1_mark_reg;
        else if (ptr_reg[ADDR_W-1:0] == ENTRY_EOF)
            sweep_data = dp_cmd.reset_marks ? EOF_MARK_RST : eof_mark_reg;
        else
            sweep_data = '0;
    end

    assign dp_sts.sweep_last  = (ptr_reg[ADDR_W-1:0] == ADDR_W'(MAP_ENTRIES - 1));
    assign dp_sts.scan_done   = ptr_reg[PTR_W-1] && !dvalid_reg;
    assign dp_sts.short_space = NEED_W'(cnt_reg) < need_reg;
    assign dp_sts.got_all     = NEED_W'(cnt_reg) == need_reg;
    assign dp_sts.head_bad    = cluster_reg < floor_w;
    assign dp_sts.walk_eof    = data_eof;
    assign dp_sts.walk_bad    = walk_bad;
    assign dp_sts.rsp_free    = rsp_free;

    always_comb
    begin
        ptr_next        = ptr_reg;
        dvalid_next     = 1'b0;
        cnt_next        = cnt_reg;
        need_next       = need_reg;
        cluster_next    = cluster_reg;
        head_next       = head_reg;
        prev_next       = prev_reg;
        rd_addr         = raddr_reg;
        mem_we          = 1'b0;
        mem_waddr       = ptr_reg[ADDR_W-1:0];
        mem_wdata       = '0;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_link_next   = rsp_link_reg;
        rsp_total_next  = rsp_total_reg;

        unique case (dp_cmd.op)
            OP_NONE:
            begin
            end
            OP_LATCH:
            begin
                need_next    = (need_raw == '0) ? NEED_W'(1) : need_raw;
                cluster_next = req_cluster;
                cnt_next     = '0;
                ptr_next     = '0;
            end
            OP_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_wdata = sweep_data;
                ptr_next  = ptr_reg + PTR_W'(1);
            end
            OP_SCAN_INIT:
            begin
                ptr_next = PTR_W'(floor_w);
                cnt_next = '0;
            end
            OP_COUNT:
            begin
                rd_addr     = ptr_reg[ADDR_W-1:0];
                dvalid_next = scan_issue;
                if (scan_issue)
                    ptr_next = ptr_reg + PTR_W'(1);
                if (free_hit)
                    cnt_next = cnt_reg + PTR_W'(1);
            end
            OP_LINK:
            begin
                rd_addr     = ptr_reg[ADDR_W-1:0];
                dvalid_next = scan_issue;
                if (scan_issue)
                    ptr_next = ptr_reg + PTR_W'(1);
                if (free_hit && !dp_sts.got_all)
                begin
                    // Chain the previous cluster to the one just found
                    if (cnt_reg != '0)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = prev_reg;
                        mem_wdata = LINK_W'(raddr_reg);
                    end
                    else
                        head_next = raddr_reg;
                    prev_next = raddr_reg;
                    cnt_next  = cnt_reg + PTR_W'(1);
                end
            end
            OP_LINK_END:
            begin
                mem_we    = 1'b1;
                mem_waddr = prev_reg;
                mem_wdata = eof_mark_reg;
            end
            OP_FREE_HEAD:
            begin
                rd_addr  = cluster_reg;
                cnt_next = PTR_W'(1);
            end
            OP_FREE_WALK:
            begin
                rd_addr = rdata_reg[ADDR_W-1:0];
                if (!walk_bad && !data_eof)
                    cnt_next = cnt_reg + PTR_W'(1);
            end
            OP_READ_CL:
                rd_addr = cluster_reg;
            OP_FREE_CLR:
            begin
                // Empty the current entry while fetching the next one
                rd_addr   = rdata_reg[ADDR_W-1:0];
                mem_we    = 1'b1;
                mem_waddr = raddr_reg;
                mem_wdata = '0;
            end
            OP_RESULT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = ST_OK;
                    rsp_link_next   = '0;
                    rsp_total_next  = '0;
                    unique case (dp_cmd.res)
                        RES_FORMAT:
                        begin
                        end
                        RES_NOSPACE: rsp_status_next = ST_NOSPACE;
                        RES_BAD:     rsp_status_next = ST_BAD;
                        RES_ALLOC:
                        begin
                            rsp_link_next  = LINK_W'(head_reg);
                            rsp_total_next = TOTAL_W'(cnt_reg);
                        end
                        RES_FREE:    rsp_total_next = TOTAL_W'(cnt_reg);
                        RES_NEXT:    rsp_link_next  = rdata_reg;
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    // Table memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            link_mem[mem_waddr] <= mem_wdata;
        rdata_reg <= link_mem[rd_addr];
    end

    // Control and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg         <= '0;
            dvalid_reg      <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            first_alloc_reg <= FIRST_ALLOC_RST;
            c0_mark_reg     <= C0_MARK_RST;
            c1_mark_reg     <= C1_MARK_RST;
            eof_mark_reg    <= EOF_MARK_RST;
        end
        else
        begin
            ptr_reg       <= ptr_next;
            dvalid_reg    <= dvalid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid)
            begin
                unique case (cfg_idx_t'(cfg.index))
                    CFG_FIRST_ALLOC: first_alloc_reg <= cfg.data[CL_W-1:0];
                    CFG_C0_MARK:     c0_mark_reg     <= cfg.data;
                    CFG_C1_MARK:     c1_mark_reg     <= cfg.data;
                    CFG_EOF_MARK:    eof_mark_reg    <= cfg.data;
                endcase
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        raddr_reg      <= rd_addr;
        cnt_reg        <= cnt_next;
        need_reg       <= need_next;
        cluster_reg    <= cluster_next;
        head_reg       <= head_next;
        prev_reg       <= prev_next;
        rsp_status_reg <= rsp_status_next;
        rsp_link_reg   <= rsp_link_next;
        rsp_total_reg  <= rsp_total_next;
    end

    assign cfg.ready         = 1'b1;
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.link          = rsp_link_reg;
    assign rsp.cluster_total = rsp_total_reg;

endmodule

[src/fat_cluster_chain_manager_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_cluster_chain_manager_core
// File allocation table of cluster links: format, allocate, free, next.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  --------+-----+-------------+-------------------------------------
//  req     | in  | valid/ready | cmd, byte_count, cluster
//  rsp     | out | valid/ready | status, link, cluster_total
//  cfg     | in  | valid/ready | index, data (always ready)
//
// One command at a time, each through the table's one read port and one
// write port at one entry per cycle: format sweeps the whole table;
// allocate runs two scans from the floor; free runs two chain walks;
// next reads one entry.
// After reset a pass over the whole table writes the format pattern; req is not ready.
// A waiting result is held in the output register; the next command is
// accepted meanwhile and finishes once that result is taken.
module fat_cluster_chain_manager_core (
    input  logic       clk,
    input  logic       rst_n,
    fccm_req_if.sink   req,
    fccm_rsp_if.source rsp,
    fccm_cfg_if.sink   cfg
);
    import fccm_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    fccm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .req_ready (req.ready),
        .dp_cmd    (dp_cmd),
        .dp_sts    (dp_sts)
    );

    fccm_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .dp_cmd         (dp_cmd),
        .dp_sts         (dp_sts),
        .req_byte_count (req.byte_count),
        .req_cluster    (req.cluster),
        .cfg            (cfg),
        .rsp            (rsp)
    );

endmodule

[src/fccm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fccm_checker
// Port-level checks of the chain manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fccm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [31:0] rsp_link,
    input logic [9:0]  rsp_total
);
    import fccm_pkg::*;

    `FCCM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")
    `FCCM_ASSERT(a_one_at_a_time, req_valid && req_ready |=> !req_ready, "second command taken while busy")
    `FCCM_ASSERT(a_err_zero, rsp_valid && (rsp_status == ST_NOSPACE || rsp_status == ST_BAD) |-> rsp_link == '0 && rsp_total == '0, "error result carries data")
    `FCCM_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !rsp_valid && !req_ready, "activity right after reset")

endmodule

bind fat_cluster_chain_manager_core fccm_checker u_fccm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_link   (rsp.link),
    .rsp_total  (rsp.cluster_total)
);
